// ===== rtl/tfc_pkg.sv =====
// Shared types, constants and plane tables for the triangle frustum clipper.
package tfc_pkg;

    localparam int COORD_W  = 32;
    localparam int POLY_MAX = 9;
    localparam int CNT_W    = 4;
    localparam int DIST_W   = 33;
    localparam int DEN_W    = 35;
    localparam int MAG_W    = 34;

    localparam logic [2:0] PLANE_LAST = 3'd5;
    localparam logic       REG_EPS    = 1'b0;
    localparam logic [15:0] EPS_RESET = 16'd1;

    typedef logic [3:0][COORD_W-1:0] vertex_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PSTART,
        ST_EDGE,
        ST_TEST,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_PUSHX,
        ST_PUSHC,
        ST_ADV,
        ST_PNEXT,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // near, far, left, bottom, right, top
    function automatic logic [1:0] plane_axis(input logic [2:0] pl);
        logic [1:0] ax;
        unique case (pl)
            3'd0, 3'd1: ax = 2'd2;
            3'd2, 3'd4: ax = 2'd0;
            3'd3, 3'd5: ax = 2'd1;
            default:    ax = 2'd0;
        endcase
        return ax;
    endfunction

    function automatic logic plane_neg(input logic [2:0] pl);
        logic ng;
        unique case (pl)
            3'd1, 3'd4, 3'd5: ng = 1'b1;
            default:          ng = 1'b0;
        endcase
        return ng;
    endfunction

endpackage

// ===== rtl/tfc_cell.sv =====
// One vertex cell of a polygon chain: load at its slot or take the neighbor's vertex.
module tfc_cell
    import tfc_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl_i,
    input  vertex_t    nb_i,
    input  vertex_t    wr_data_i,
    output vertex_t    q_o
);

    vertex_t vertex_reg;
    vertex_t vertex_next;

    always_comb begin
        vertex_next = vertex_reg;
        if (ctrl_i.wr) begin
            vertex_next = wr_data_i;
        end else if (ctrl_i.shift) begin
            vertex_next = nb_i;
        end
    end

    always_ff @(posedge aclk) begin
        vertex_reg <= vertex_next;
    end

    assign q_o = vertex_reg;

endmodule

// ===== rtl/tfc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the fraction num/den with num < den.
module tfc_div
    import tfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start_i,
    input  logic [MAG_W-1:0]     num_i,
    input  logic [MAG_W-1:0]     den_i,
    output logic                 done_o,
    output logic [FRAC_BITS-1:0] quot_o
);

    localparam int STEP_W = $clog2(FRAC_BITS + 1);

    logic              act_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  den_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [MAG_W:0]    rem_dbl;
    logic              fits;

    assign rem_dbl = {rem_reg, 1'b0};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= 1'b0;
            step_reg <= '0;
        end else if (start_i) begin
            act_reg  <= 1'b1;
            step_reg <= STEP_W'(FRAC_BITS);
        end else if (act_reg && step_reg != '0) begin
            step_reg <= step_reg - STEP_W'(1);
        end else begin
            act_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            rem_reg <= num_i;
            den_reg <= den_i;
            q_reg   <= '0;
        end else if (act_reg && step_reg != '0) begin
            rem_reg <= fits ? MAG_W'(rem_dbl - {1'b0, den_reg}) : rem_dbl[MAG_W-1:0];
            q_reg   <= {q_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign done_o = act_reg && step_reg == '0;
    assign quot_o = q_reg;

endmodule

// ===== rtl/triangle_frustum_clipper.sv =====
// Top level: triangle collection, six-plane clipping sequencer over two vertex chains, output.
//
//  channel | dir | handshake               | content
//  s_      | in  | s_tvalid / s_tready     | one vertex request: x, y, z, w
//  m_      | out | m_tvalid / m_tready     | polygon vertex, tlast, tuser = empty flag
//  apb     | in  | psel/penable/pready     | inside_epsilon at byte address 0
//
// Vertices are taken one per cycle; the third starts clipping, or goes straight to output when all
// three lie inside the frustum, and input stalls until the polygon is out. Each edge crossing
// runs the bit-serial divider (skipped when t clamps to 0 or 1), then a shared multiplier for
// four coordinates. Output drains one vertex per cycle from the chain head into a registered
// output stage while m_tready allows; a stall holds the sequencer in its output states.
// Reset is synchronous and needs no clearing pass.
module triangle_frustum_clipper
    import tfc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, pos_z, pos_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_w
    output logic         m_tlast,
    output logic [0:0]   m_tuser,   // empty_polygon
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int PW = DIST_W + FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    function automatic logic signed [DIST_W-1:0] plane_dist(input vertex_t v,
                                                            input logic [2:0] pl);
        logic signed [DIST_W-1:0] c;
        logic signed [DIST_W-1:0] w;
        c = DIST_W'($signed(v[plane_axis(pl)]));
        w = DIST_W'($signed(v[3]));
        return plane_neg(pl) ? w - c : w + c;
    endfunction

    function automatic logic inside_of(input logic signed [DIST_W-1:0] d,
                                       input logic [15:0] eps);
        logic signed [DIST_W:0] s;
        s = (DIST_W + 1)'(d) + $signed({{(DIST_W - 15){1'b0}}, eps});
        return !s[DIST_W] && s != '0;
    endfunction

    function automatic logic [DIST_W-1:0] abs33(input logic [COORD_W-1:0] x);
        logic signed [DIST_W-1:0] e;
        e = DIST_W'($signed(x));
        return e[DIST_W-1] ? DIST_W'(-e) : DIST_W'(e);
    endfunction

    state_t state_reg, state_next;

    logic [2:0]       plane_reg;
    logic             sel_reg;
    logic [CNT_W-1:0] cnt_reg [2];
    vertex_t          last_v_reg [2];
    logic [1:0]       slot_reg;
    logic             all_in_reg;
    logic [15:0]      eps_reg;
    logic [1:0]       k_reg;

    vertex_t prev_reg, cur_reg, cross_reg;
    logic signed [DIST_W-1:0] da_reg, db_reg;
    logic cin_reg, pin_reg;
    logic [FRAC_BITS:0] t_reg;
    logic signed [PW-1:0] prod_reg;

    logic             m_valid_reg;
    logic [127:0]     m_data_reg;
    logic             m_last_reg;
    logic             m_empty_reg;

    logic [1:0]       pop, push, clr;
    logic [CNT_W-1:0] push_idx [2];
    vertex_t          push_data;
    vertex_t          cell_q [2][POLY_MAX];
    vertex_t          src_head;
    logic             src, dst;

    logic out_free, out_load, out_empty;
    logic div_start, div_done;
    logic [FRAC_BITS-1:0] quot;
    logic all_in_cur, all_in_next;
    logic dst_room;

    logic signed [DEN_W-1:0] den_raw, num_raw, den_abs, num_abs;
    logic t_zero, t_one;
    logic signed [DIST_W-1:0] diff;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] rnd_sh;
    logic cfg_wr;

    assign src      = sel_reg;
    assign dst      = ~sel_reg;
    assign src_head = cell_q[src][0];
    assign out_free = !m_valid_reg || m_tready;
    assign dst_room = cnt_reg[dst] < CNT_W'(POLY_MAX);

    for (genvar c = 0; c < 2; c++) begin : g_chain
        for (genvar i = 0; i < POLY_MAX; i++) begin : g_cell
            cell_ctrl_t ctrl;
            vertex_t    nb;
            assign ctrl.shift = pop[c];
            assign ctrl.wr    = push[c] && push_idx[c] == CNT_W'(i);
            if (i == POLY_MAX - 1) begin : g_tail
                assign nb = cell_q[c][i];
            end else begin : g_mid
                assign nb = cell_q[c][i+1];
            end
            tfc_cell u_cell (
                .aclk      (aclk),
                .ctrl_i    (ctrl),
                .nb_i      (nb),
                .wr_data_i (push_data),
                .q_o       (cell_q[c][i])
            );
        end
    end

    always_comb begin
        vertex_t v;
        logic [DIST_W-1:0] aw;
        v  = vertex_t'(s_tdata);
        aw = abs33(v[3]);
        all_in_cur  = !(abs33(v[0]) > aw || abs33(v[1]) > aw || abs33(v[2]) > aw);
        all_in_next = all_in_cur && (slot_reg == 2'd0 || all_in_reg);
    end

    always_comb begin
        den_raw = DEN_W'(da_reg) - DEN_W'(db_reg);
        num_raw = DEN_W'(da_reg);
        den_abs = den_raw[DEN_W-1] ? -den_raw : den_raw;
        num_abs = den_raw[DEN_W-1] ? -num_raw : num_raw;
        t_zero  = den_abs == '0 || num_abs[DEN_W-1] || num_abs == '0;
        t_one   = num_abs >= den_abs;
    end

    tfc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .num_i   (num_abs[MAG_W-1:0]),
        .den_i   (den_abs[MAG_W-1:0]),
        .done_o  (div_done),
        .quot_o  (quot)
    );

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        pop         = '0;
        push        = '0;
        clr         = '0;
        push_idx[0] = cnt_reg[0];
        push_idx[1] = cnt_reg[1];
        push_data   = cur_reg;
        out_load    = 1'b0;
        out_empty   = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                push_data = vertex_t'(s_tdata);
                push_idx[0] = CNT_W'(slot_reg);
                if (s_tvalid) begin
                    push[0] = 1'b1;
                    if (slot_reg == 2'd2) begin
                        state_next = all_in_next ? ST_EMIT : ST_PSTART;
                    end
                end
            end
            ST_PSTART: begin
                clr[dst] = 1'b1;
                state_next = (cnt_reg[src] == '0) ? ST_PNEXT : ST_EDGE;
            end
            ST_EDGE: begin
                pop[src] = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (cin_reg != pin_reg) begin
                    if (t_zero || t_one) begin
                        state_next = ST_MUL;
                    end else begin
                        div_start = 1'b1;
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = cin_reg ? ST_PUSHC : ST_ADV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = (k_reg == 2'd3) ? ST_PUSHX : ST_MUL;
            end
            ST_PUSHX: begin
                push_data = cross_reg;
                push[dst] = dst_room;
                state_next = cin_reg ? ST_PUSHC : ST_ADV;
            end
            ST_PUSHC: begin
                push_data = cur_reg;
                push[dst] = dst_room;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                state_next = (cnt_reg[src] == '0) ? ST_PNEXT : ST_EDGE;
            end
            ST_PNEXT: begin
                if (plane_reg == PLANE_LAST) begin
                    state_next = (cnt_reg[dst] == '0) ? ST_EMPTY : ST_EMIT;
                end else begin
                    state_next = ST_PSTART;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    pop[src] = 1'b1;
                    if (cnt_reg[src] == CNT_W'(1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_empty = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cfg_wr = psel && penable && pwrite && paddr[2] == REG_EPS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg  <= '0;
            sel_reg    <= 1'b0;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            slot_reg   <= '0;
            all_in_reg <= 1'b0;
            eps_reg    <= EPS_RESET;
            k_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                eps_reg <= pwdata[15:0];
            end
            for (int c = 0; c < 2; c++) begin
                if (push[c]) begin
                    cnt_reg[c] <= push_idx[c] + CNT_W'(1);
                end else if (pop[c]) begin
                    cnt_reg[c] <= cnt_reg[c] - CNT_W'(1);
                end else if (clr[c]) begin
                    cnt_reg[c] <= '0;
                end
            end
            if (state_reg == ST_LOAD && s_tvalid) begin
                slot_reg   <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                all_in_reg <= all_in_next;
                sel_reg    <= 1'b0;
                plane_reg  <= '0;
            end
            if (state_reg == ST_ADD) begin
                k_reg <= k_reg + 2'd1;
            end
            if (state_reg == ST_PNEXT) begin
                sel_reg   <= ~sel_reg;
                plane_reg <= (plane_reg == PLANE_LAST) ? 3'd0 : plane_reg + 3'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign diff = DIST_W'($signed(cur_reg[k_reg])) - DIST_W'($signed(prev_reg[k_reg]));
    assign rnd    = prod_reg + HALF;
    assign rnd_sh = rnd >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 2; c++) begin
            if (push[c]) begin
                last_v_reg[c] <= push_data;
            end
        end
        unique case (state_reg)
            ST_PSTART: prev_reg <= last_v_reg[src];
            ST_EDGE:   cur_reg  <= src_head;
            ST_TEST: begin
                da_reg  <= plane_dist(prev_reg, plane_reg);
                db_reg  <= plane_dist(cur_reg, plane_reg);
                pin_reg <= inside_of(plane_dist(prev_reg, plane_reg), eps_reg);
                cin_reg <= inside_of(plane_dist(cur_reg, plane_reg), eps_reg);
            end
            ST_SETUP:  t_reg <= t_zero ? '0 : T_ONE;
            ST_DIV: begin
                if (div_done) begin
                    t_reg <= {1'b0, quot};
                end
            end
            ST_MUL:    prod_reg <= PW'(diff) * $signed({1'b0, t_reg});
            ST_ADD:    cross_reg[k_reg] <= prev_reg[k_reg] + rnd_sh[COORD_W-1:0];
            ST_ADV:    prev_reg <= cur_reg;
            default: ;
        endcase
        if (out_load) begin
            m_data_reg  <= out_empty ? '0 : 128'(src_head);
            m_last_reg  <= out_empty || cnt_reg[src] == CNT_W'(1);
            m_empty_reg <= out_empty;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_EPS) ? {16'd0, eps_reg} : 32'd0;

endmodule
